// ===== hw/rtl/kol_pkg.sv =====
// Package for the keyed ordered list: operation and status codes, field
// widths, default sizes and the sequencer state type.
// No dependencies; used by keyed_ordered_list_core.
`default_nettype none

package kol_pkg;

   localparam int DEFAULT_CAPACITY = 2048;
   localparam int DEFAULT_KEY_BITS = 32;

   localparam int FIELD_KEY_BITS = 32;
   localparam int INDEX_BITS     = 11;
   localparam int POS_BITS       = 11;
   localparam int LEN_BITS       = 12;
   localparam int OP_BITS        = 2;
   localparam int STAT_BITS      = 2;

   localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_BITS-1:0] OP_READ   = 2'd3;

   localparam logic [STAT_BITS-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_MISSING = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_RANGE   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_READ_WAIT,
      S_DONE
   } kol_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/keyed_ordered_list_core.sv =====
// Keyed ordered list: keys held in one synchronous memory, with a sequencer
// that searches and shifts entries one per cycle. Depends on kol_pkg.
//
// Usage:
// The request channel (req_) carries one operation per item: append a key at
// the tail, insert a key before the first entry equal to a target, remove
// the first entry equal to a target, or read the entry at an index. Every
// request yields exactly one response item on the rsp_ channel with the key
// read, a position, a status code and the list length after the operation.
// Requests are handled one at a time. Insert and remove walk the memory
// through its single read port, one entry per cycle: the search runs from
// the head to the first match or the tail, and the shift moves the entries
// between the match and the tail. A new request is taken once the previous
// one has left the sequencer, even while its response still waits in the
// output register. A stalled response holds its item until rsp_tready, and
// a finished item waits in the sequencer for the output register to free.
// Synchronous reset empties the list and drops any pending response; the
// key memory itself is not cleared, since entries are read only once written.
`default_nettype none

module keyed_ordered_list_core #(
   parameter int CAPACITY = kol_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS = kol_pkg::DEFAULT_KEY_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // new_key [31:0], target_key [63:32], index [74:64], zero [79:75]
   input  wire logic [79:0] req_tdata,
   // opcode [1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // key_out [31:0], position [42:32], length [54:43], zero [55]
   output logic [55:0]      rsp_tdata,
   // status [1:0]
   output logic [1:0]       rsp_tuser
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > kol_pkg::INDEX_BITS) ? CW : kol_pkg::INDEX_BITS;

   logic [KEY_BITS-1:0] entries_mem [CAPACITY];

   kol_pkg::kol_state_type state_ff, state_in;

   logic [CW-1:0]                    count_ff, count_in;
   logic [kol_pkg::OP_BITS-1:0]      op_ff, op_in;
   logic [KEY_BITS-1:0]              nkey_ff, nkey_in;
   logic [KEY_BITS-1:0]              tkey_ff, tkey_in;
   logic [CW-1:0]                    scan_ff, scan_in;
   logic                             pend_ff, pend_in;
   logic [AW-1:0]                    pidx_ff, pidx_in;
   logic [AW-1:0]                    src_ff, src_in;
   logic                             more_ff, more_in;
   logic [AW-1:0]                    at_ff, at_in;
   logic [kol_pkg::FIELD_KEY_BITS-1:0] res_key_ff, res_key_in;
   logic [kol_pkg::POS_BITS-1:0]     res_pos_ff, res_pos_in;
   logic [kol_pkg::STAT_BITS-1:0]    res_stat_ff, res_stat_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [kol_pkg::FIELD_KEY_BITS-1:0] rsp_key_ff;
   logic [kol_pkg::POS_BITS-1:0]     rsp_pos_ff;
   logic [kol_pkg::STAT_BITS-1:0]    rsp_stat_ff;
   logic [kol_pkg::LEN_BITS-1:0]     rsp_len_ff;
   logic                             rsp_load;

   logic [KEY_BITS-1:0] rd_data_ff;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [KEY_BITS-1:0] wr_data;

   logic [kol_pkg::OP_BITS-1:0]    req_op;
   logic [KEY_BITS-1:0]            req_nkey;
   logic [KEY_BITS-1:0]            req_tkey;
   logic [kol_pkg::INDEX_BITS-1:0] req_index;

   logic req_fire, full, hit, scan_more, in_range;

   assign req_op    = req_tuser;
   assign req_nkey  = KEY_BITS'(req_tdata[31:0]);
   assign req_tkey  = KEY_BITS'(req_tdata[63:32]);
   assign req_index = req_tdata[74:64];

   assign req_tready = (state_ff == kol_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(CAPACITY));
   assign hit        = pend_ff && (rd_data_ff == tkey_ff);
   assign scan_more  = (scan_ff < count_ff);
   assign in_range   = (CMPW'(req_index) < CMPW'(count_ff));
   assign rsp_load   = (state_ff == kol_pkg::S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kol_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_op inside {kol_pkg::OP_INSERT, kol_pkg::OP_REMOVE}) begin
                  state_in = kol_pkg::S_SEARCH;
               end else if (req_op == kol_pkg::OP_READ && in_range) begin
                  state_in = kol_pkg::S_READ_WAIT;
               end else begin
                  state_in = kol_pkg::S_DONE;
               end
            end
         end
         kol_pkg::S_SEARCH: begin
            if (hit) begin
               if (op_ff == kol_pkg::OP_INSERT) begin
                  state_in = full ? kol_pkg::S_DONE : kol_pkg::S_SHIFT_UP;
               end else begin
                  state_in = kol_pkg::S_SHIFT_DN;
               end
            end else if (!scan_more) begin
               state_in = kol_pkg::S_DONE;
            end
         end
         kol_pkg::S_SHIFT_UP, kol_pkg::S_SHIFT_DN: begin
            if (!more_ff && !pend_ff) begin
               state_in = kol_pkg::S_DONE;
            end
         end
         kol_pkg::S_READ_WAIT: begin
            state_in = kol_pkg::S_DONE;
         end
         kol_pkg::S_DONE: begin
            if (rsp_load) begin
               state_in = kol_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kol_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      op_in       = op_ff;
      nkey_in     = nkey_ff;
      tkey_in     = tkey_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      src_in      = src_ff;
      more_in     = more_ff;
      at_in       = at_ff;
      res_key_in  = res_key_ff;
      res_pos_in  = res_pos_ff;
      res_stat_in = res_stat_ff;
      rd_en       = 1'b0;
      rd_addr     = AW'(scan_ff);
      wr_en       = 1'b0;
      wr_addr     = AW'(count_ff);
      wr_data     = nkey_ff;
      case (state_ff)
         kol_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in       = req_op;
               nkey_in     = req_nkey;
               tkey_in     = req_tkey;
               scan_in     = '0;
               res_key_in  = '0;
               res_pos_in  = '0;
               res_stat_in = kol_pkg::STAT_OK;
               case (req_op)
                  kol_pkg::OP_APPEND: begin
                     if (full) begin
                        res_stat_in = kol_pkg::STAT_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(count_ff);
                        wr_data    = req_nkey;
                        count_in   = count_ff + CW'(1);
                        res_pos_in = kol_pkg::POS_BITS'(count_ff);
                     end
                  end
                  kol_pkg::OP_READ: begin
                     if (in_range) begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(req_index);
                        res_pos_in = req_index;
                     end else begin
                        res_stat_in = kol_pkg::STAT_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         kol_pkg::S_SEARCH: begin
            if (hit) begin
               at_in      = pidx_ff;
               res_pos_in = kol_pkg::POS_BITS'(pidx_ff);
               if (op_ff == kol_pkg::OP_INSERT) begin
                  if (full) begin
                     res_pos_in  = '0;
                     res_stat_in = kol_pkg::STAT_FULL;
                  end
                  src_in  = AW'(count_ff - CW'(1));
                  more_in = 1'b1;
               end else begin
                  src_in  = pidx_ff + AW'(1);
                  more_in = (CW'(pidx_ff) + CW'(1)) < count_ff;
               end
            end else if (scan_more) begin
               rd_en   = 1'b1;
               rd_addr = AW'(scan_ff);
               pend_in = 1'b1;
               pidx_in = AW'(scan_ff);
               scan_in = scan_ff + CW'(1);
            end else begin
               res_stat_in = kol_pkg::STAT_MISSING;
            end
         end
         kol_pkg::S_SHIFT_UP: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff + AW'(1);
               wr_data = rd_data_ff;
            end
            if (more_ff) begin
               rd_en   = 1'b1;
               rd_addr = src_ff;
               pend_in = 1'b1;
               pidx_in = src_ff;
               if (src_ff == at_ff) begin
                  more_in = 1'b0;
               end else begin
                  src_in = src_ff - AW'(1);
               end
            end else if (!pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = at_ff;
               wr_data  = nkey_ff;
               count_in = count_ff + CW'(1);
            end
         end
         kol_pkg::S_SHIFT_DN: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff - AW'(1);
               wr_data = rd_data_ff;
            end
            if (more_ff) begin
               rd_en   = 1'b1;
               rd_addr = src_ff;
               pend_in = 1'b1;
               pidx_in = src_ff;
               if ((CW'(src_ff) + CW'(1)) == count_ff) begin
                  more_in = 1'b0;
               end else begin
                  src_in = src_ff + AW'(1);
               end
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
            end
         end
         kol_pkg::S_READ_WAIT: begin
            res_key_in = kol_pkg::FIELD_KEY_BITS'(rd_data_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kol_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      nkey_ff     <= nkey_in;
      tkey_ff     <= tkey_in;
      scan_ff     <= scan_in;
      pidx_ff     <= pidx_in;
      src_ff      <= src_in;
      at_ff       <= at_in;
      res_key_ff  <= res_key_in;
      res_pos_ff  <= res_pos_in;
      res_stat_ff <= res_stat_in;
      if (rsp_load) begin
         rsp_key_ff  <= res_key_ff;
         rsp_pos_ff  <= res_pos_ff;
         rsp_stat_ff <= res_stat_ff;
         rsp_len_ff  <= kol_pkg::LEN_BITS'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff, rsp_pos_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_stat_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("memory write beyond the list tail");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != kol_pkg::S_IDLE))
      else $error("sequencer idle right after accepting an item");

   a_one_op_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff != kol_pkg::S_IDLE) |-> !req_tready)
      else $error("request accepted while an item is in progress");
`endif

endmodule

`default_nettype wire
